// File: src/qat_pkg.sv
// ----------------------------------------------------------------------------
// qat_pkg
// Shared types and constants for the quoted argument tokenizer.
// ----------------------------------------------------------------------------
package qat_pkg;

  // Default argument count ceiling
  localparam int unsigned MaxArgsDefault = 255;

  // Scanner mode codes
  localparam logic [2:0] ModeBetween   = 3'd0;
  localparam logic [2:0] ModeBare      = 3'd1;
  localparam logic [2:0] ModeBareEsc   = 3'd2;
  localparam logic [2:0] ModeQuoted    = 3'd3;
  localparam logic [2:0] ModeQuotedEsc = 3'd4;
  localparam logic [2:0] ModeClosed    = 3'd5;
  localparam logic [2:0] ModeError     = 3'd6;

  // Result kinds
  localparam logic [1:0] KindByte    = 2'd0;
  localparam logic [1:0] KindArgEnd  = 2'd1;
  localparam logic [1:0] KindLineEnd = 2'd2;

  // Status codes
  localparam logic StatusOk       = 1'b0;
  localparam logic StatusBadQuote = 1'b1;

  // Characters of interest
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;

  // Result queue geometry
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] arg_byte;
    logic       status;
    logic [7:0] arg_count;
    logic       run_last;
  } result_t;

endpackage

// File: src/quoted_argument_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_unit
// Splits a NUL-terminated command line into arguments, one byte a transfer.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                   | marks
//  ---------+-----+-------------------------------------------+-----------------
//  s_axis   | in  | tdata[7:0] line_byte                      | -
//  m_axis   | out | tdata: arg_byte, status, arg_count; tuser | tlast = run_last
//           |     | kind                                      |
//
//  One input byte is taken per cycle. The scanner decodes it against the
//  registered mode combinationally and writes its zero, one or two results
//  into a four-entry result queue; results leave at one per cycle while
//  m_axis_tready_i is high. s_axis_tready_o is high while the queue has room
//  for two results, so input stalls only when the output side holds back or a
//  byte yields two results. rst_ni (asynchronous, active low) empties the
//  queue and returns the scanner to between-arguments with a zero count.
//
module quoted_argument_tokenizer_unit #(
  parameter int unsigned MAX_ARGS = qat_pkg::MaxArgsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] line_byte

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] arg_byte, [8] status,
                                        // [16:9] arg_count, [23:17] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o    // last result of this input byte
);

  localparam logic [7:0] MaxArgsC = 8'(MAX_ARGS);

  // Scanner state
  logic [2:0] mode_q, mode_d;
  logic       single_q, single_d;
  logic [7:0] args_q, args_d;

  // Result queue
  qat_pkg::result_t                      queue_q [qat_pkg::QueueDepth];
  logic [qat_pkg::QueuePtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [qat_pkg::QueueCntW-1:0]         count_q;

  logic                                  accept, pop;
  logic [1:0]                            n_res;
  qat_pkg::result_t                      res0, res1;
  logic [7:0]                            b;
  logic [7:0]                            quote_ch;
  logic [7:0]                            args_inc;
  logic                                  is_sep;

  function automatic qat_pkg::result_t mk(input logic [1:0] kind, input logic [7:0] byt,
                                          input logic st, input logic [7:0] cnt);
    qat_pkg::result_t r;
    r.kind      = kind;
    r.arg_byte  = byt;
    r.status    = st;
    r.arg_count = cnt;
    r.run_last  = 1'b0;
    return r;
  endfunction

  assign s_axis_tready_o = (count_q <= qat_pkg::QueueCntW'(qat_pkg::QueueDepth - 2));
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = (count_q != '0);
  assign pop             = m_axis_tvalid_o & m_axis_tready_i;

  assign b        = s_axis_tdata_i;
  assign quote_ch = single_q ? qat_pkg::ChSquote : qat_pkg::ChDquote;
  assign is_sep   = (b <= qat_pkg::ChSpace);
  // saturating count of a finished argument
  assign args_inc = (args_q < MaxArgsC) ? args_q + 8'd1 : MaxArgsC;

  // Scanner decode: one byte against the current mode
  always_comb begin
    mode_d   = mode_q;
    single_d = single_q;
    args_d   = args_q;
    n_res    = 2'd0;
    res0     = '0;
    res1     = '0;

    unique case (mode_q) inside
      qat_pkg::ModeBetween: begin
        if (b == qat_pkg::ChNul) begin
          res0  = mk(qat_pkg::KindLineEnd, 8'd0, qat_pkg::StatusOk, args_q);
          n_res = 2'd1;
          mode_d = qat_pkg::ModeBetween; single_d = 1'b0; args_d = '0;
        end else if (is_sep) begin
          mode_d = qat_pkg::ModeBetween;
        end else if (b == qat_pkg::ChDquote || b == qat_pkg::ChSquote) begin
          single_d = (b == qat_pkg::ChSquote);
          mode_d   = qat_pkg::ModeQuoted;
        end else if (b == qat_pkg::ChBslash) begin
          mode_d = qat_pkg::ModeBareEsc;
        end else begin
          res0   = mk(qat_pkg::KindByte, b, qat_pkg::StatusOk, 8'd0);
          n_res  = 2'd1;
          mode_d = qat_pkg::ModeBare;
        end
      end
      qat_pkg::ModeBare: begin
        if (b == qat_pkg::ChNul) begin
          // argument and line end together: two results
          res0  = mk(qat_pkg::KindArgEnd, 8'd0, qat_pkg::StatusOk, 8'd0);
          res1  = mk(qat_pkg::KindLineEnd, 8'd0, qat_pkg::StatusOk, args_inc);
          n_res = 2'd2;
          mode_d = qat_pkg::ModeBetween; single_d = 1'b0; args_d = '0;
        end else if (is_sep) begin
          res0   = mk(qat_pkg::KindArgEnd, 8'd0, qat_pkg::StatusOk, 8'd0);
          n_res  = 2'd1;
          args_d = args_inc;
          mode_d = qat_pkg::ModeBetween;
        end else if (b == qat_pkg::ChDquote) begin
          mode_d = qat_pkg::ModeError;
        end else if (b == qat_pkg::ChBslash) begin
          mode_d = qat_pkg::ModeBareEsc;
        end else begin
          res0  = mk(qat_pkg::KindByte, b, qat_pkg::StatusOk, 8'd0);
          n_res = 2'd1;
        end
      end
      qat_pkg::ModeBareEsc, qat_pkg::ModeQuotedEsc: begin
        if (b == qat_pkg::ChNul) begin
          res0  = mk(qat_pkg::KindLineEnd, 8'd0, qat_pkg::StatusBadQuote, args_q);
          n_res = 2'd1;
          mode_d = qat_pkg::ModeBetween; single_d = 1'b0; args_d = '0;
        end else begin
          res0   = mk(qat_pkg::KindByte, b, qat_pkg::StatusOk, 8'd0);
          n_res  = 2'd1;
          mode_d = (mode_q == qat_pkg::ModeBareEsc) ? qat_pkg::ModeBare
                                                    : qat_pkg::ModeQuoted;
        end
      end
      qat_pkg::ModeQuoted: begin
        if (b == qat_pkg::ChNul) begin
          res0  = mk(qat_pkg::KindLineEnd, 8'd0, qat_pkg::StatusBadQuote, args_q);
          n_res = 2'd1;
          mode_d = qat_pkg::ModeBetween; single_d = 1'b0; args_d = '0;
        end else if (b == qat_pkg::ChBslash) begin
          mode_d = qat_pkg::ModeQuotedEsc;
        end else if (b == quote_ch) begin
          res0   = mk(qat_pkg::KindArgEnd, 8'd0, qat_pkg::StatusOk, 8'd0);
          n_res  = 2'd1;
          args_d = args_inc;
          mode_d = qat_pkg::ModeClosed;
        end else begin
          res0  = mk(qat_pkg::KindByte, b, qat_pkg::StatusOk, 8'd0);
          n_res = 2'd1;
        end
      end
      qat_pkg::ModeClosed: begin
        if (b == qat_pkg::ChNul) begin
          res0  = mk(qat_pkg::KindLineEnd, 8'd0, qat_pkg::StatusOk, args_q);
          n_res = 2'd1;
          mode_d = qat_pkg::ModeBetween; single_d = 1'b0; args_d = '0;
        end else if (is_sep) begin
          mode_d = qat_pkg::ModeBetween;
        end else begin
          mode_d = qat_pkg::ModeError;
        end
      end
      default: begin
        // error (and unused codes): swallow until end of line
        if (b == qat_pkg::ChNul) begin
          res0  = mk(qat_pkg::KindLineEnd, 8'd0, qat_pkg::StatusBadQuote, args_q);
          n_res = 2'd1;
          mode_d = qat_pkg::ModeBetween; single_d = 1'b0; args_d = '0;
        end else begin
          mode_d = qat_pkg::ModeError;
        end
      end
    endcase

    if (n_res == 2'd2) begin
      res1.run_last = 1'b1;
    end else begin
      res0.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= qat_pkg::ModeBetween;
      single_q <= 1'b0;
      args_q   <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (accept) begin
        mode_q   <= mode_d;
        single_q <= single_d;
        args_q   <= args_d;
        wr_ptr_q <= wr_ptr_q + qat_pkg::QueuePtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (accept ? qat_pkg::QueueCntW'(n_res) : '0)
                         - qat_pkg::QueueCntW'(pop);
    end
  end

  // Queue payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (accept && n_res == 2'd2) begin
      queue_q[wr_ptr_q + 1'b1] <= res1;
    end
  end

  assign m_axis_tdata_o = {7'd0, queue_q[rd_ptr_q].arg_count,
                           queue_q[rd_ptr_q].status, queue_q[rd_ptr_q].arg_byte};
  assign m_axis_tuser_o = queue_q[rd_ptr_q].kind;
  assign m_axis_tlast_o = queue_q[rd_ptr_q].run_last;

endmodule
